FILE: hw/rtl/ials_pkg.sv
// Shared definitions for the indexed array list engine.
// Holds sizes, operation and status codes, sequencer states and the store write request.
// No dependencies.
package ials_pkg;

  // Store geometry.
  localparam int DEPTH      = 32;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  // Requested operation of an item.
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_EDIT   = 3'd2,
    OP_DELETE = 3'd3,
    OP_GET    = 3'd4,
    OP_FIND   = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADIDX   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_GET,
    S_FIND
  } state_t;

  // One write request into the entry store.
  typedef struct packed {
    logic                  en;
    logic [AW-1:0]         addr;
    logic [DATA_WIDTH-1:0] data;
  } wr_t;

endpackage

FILE: hw/rtl/ials_store.sv
// Entry store of the indexed array list engine: one write port, one registered read port.
// Depends on ials_pkg.
module ials_store
  import ials_pkg::*;
(
  input  logic                  clk,
  input  wr_t                   wr,
  input  logic [AW-1:0]         rd_addr,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/indexed_array_list_engine_top.sv
// Top level of the indexed array list engine.
// Depends on ials_pkg and ials_store.
//
// Usage:
// An item is taken at a rising edge with start high and busy low. It carries in_op,
// in_position and in_value. Each item gives exactly one result, shown for one cycle
// with out_valid high; the receiver cannot hold it off.
// The user must write the capacity register over cfg_valid/cfg_ready/cfg_data only
// while idle; the block does not enforce this. cfg_ready is always high.
// Reset sets the capacity to 32 and the count to zero. How each operation finishes:
//   append, edit, unused codes and errors: never busy, so such items run back to back.
//   get: the registered store read, then the result from S_GET.
//   find: S_FIND, one stored entry compared per cycle.
//   insert: read/write shifts from the end down to the position, then S_PUT; none at the end.
//   delete: read/write shifts from the position toward the end; none for the last entry.
// Insert and delete move one entry at a time through the single store port pair
// (read, then write), which sets their cost. busy stays high until the result is made.
// No clearing pass is needed after reset: only entries below the count are ever used.
module indexed_array_list_engine_top
  import ials_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [4:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [4:0]  out_found_position,
  output logic [5:0]  out_entry_count,
  output logic        out_is_full,
  output logic        out_is_empty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [5:0]            cap_r;
  op_t                   op_r, op_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         fpos_r, fpos_nxt;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [31:0]           out_read_value_r;
  logic [4:0]            out_found_position_r;
  logic [5:0]            out_entry_count_r;
  logic                  out_is_full_r;
  logic                  out_is_empty_r;

  wr_t                   wr_c;
  logic [AW-1:0]         rd_addr_c;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  fin_c;
  status_t               fin_status_c;
  logic [DATA_WIDTH-1:0] fin_rd_c;
  logic [AW-1:0]         fin_fpos_c;

  logic [CW-1:0]         cap_eff;
  logic                  full_c;
  logic                  accept_c;
  logic [CW-1:0]         in_pos_c;
  logic [DATA_WIDTH-1:0] in_val_c;
  logic                  hit_c;

  ials_store u_store (
    .clk     (clk),
    .wr      (wr_c),
    .rd_addr (rd_addr_c),
    .rd_data (rd_data)
  );

  // Effective capacity is the register capped at the store depth.
  assign cap_eff  = (CW'(cap_r) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_r);
  assign full_c   = count_r >= cap_eff;
  assign accept_c = start && (state_r == S_IDLE);
  assign in_pos_c = CW'(in_position);
  assign in_val_c = in_value[DATA_WIDTH-1:0];
  assign hit_c    = (rd_data == val_r);
  assign cfg_ready = 1'b1;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 6'd32;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // Sequencer and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin_c;
    end
  end

  // Item payload, scan state and result registers.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    found_r <= found_nxt;
    fpos_r  <= fpos_nxt;
    if (fin_c) begin
      out_status_r         <= fin_status_c;
      out_read_value_r     <= 32'(fin_rd_c);
      out_found_position_r <= 5'(fin_fpos_c);
      out_entry_count_r    <= 6'(count_nxt);
      out_is_full_r        <= count_nxt >= cap_eff;
      out_is_empty_r       <= count_nxt == '0;
    end
  end

  // Next state, store accesses and result formation.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    op_nxt       = op_r;
    pos_nxt      = pos_r;
    val_nxt      = val_r;
    idx_nxt      = idx_r;
    found_nxt    = found_r;
    fpos_nxt     = fpos_r;
    wr_c         = '0;
    rd_addr_c    = idx_r;
    fin_c        = 1'b0;
    fin_status_c = ST_OK;
    fin_rd_c     = '0;
    fin_fpos_c   = '0;

    case (state_r)
      S_IDLE: begin
        rd_addr_c = in_position[AW-1:0];
        if (accept_c) begin
          op_nxt    = op_t'(in_op);
          pos_nxt   = in_position[AW-1:0];
          val_nxt   = in_val_c;
          found_nxt = 1'b0;
          fpos_nxt  = '0;
          case (op_t'(in_op))
            OP_APPEND: begin
              fin_c = 1'b1;
              if (full_c) begin
                fin_status_c = ST_FULL;
              end else begin
                wr_c      = '{en: 1'b1, addr: count_r[AW-1:0], data: in_val_c};
                count_nxt = count_r + CW'(1);
              end
            end
            OP_INSERT: begin
              if (full_c) begin
                fin_c        = 1'b1;
                fin_status_c = ST_FULL;
              end else if (in_pos_c > count_r) begin
                fin_c        = 1'b1;
                fin_status_c = ST_BADIDX;
              end else if (in_pos_c == count_r) begin
                // Insert at the end is an append.
                fin_c     = 1'b1;
                wr_c      = '{en: 1'b1, addr: in_position[AW-1:0], data: in_val_c};
                count_nxt = count_r + CW'(1);
              end else begin
                idx_nxt   = count_r[AW-1:0];
                state_nxt = S_SHIFT_RD;
              end
            end
            OP_EDIT: begin
              fin_c = 1'b1;
              if (in_pos_c >= count_r) begin
                fin_status_c = ST_BADIDX;
              end else begin
                wr_c = '{en: 1'b1, addr: in_position[AW-1:0], data: in_val_c};
              end
            end
            OP_DELETE: begin
              if (count_r == '0) begin
                fin_c        = 1'b1;
                fin_status_c = ST_EMPTY;
              end else if (in_pos_c >= count_r) begin
                fin_c        = 1'b1;
                fin_status_c = ST_BADIDX;
              end else if (in_pos_c == count_r - CW'(1)) begin
                // Deleting the last entry moves nothing.
                fin_c     = 1'b1;
                count_nxt = count_r - CW'(1);
              end else begin
                idx_nxt   = in_position[AW-1:0];
                state_nxt = S_SHIFT_RD;
              end
            end
            OP_GET: begin
              if (in_pos_c >= count_r) begin
                fin_c        = 1'b1;
                fin_status_c = ST_BADIDX;
              end else begin
                state_nxt = S_GET;
              end
            end
            OP_FIND: begin
              rd_addr_c = '0;
              if (count_r == '0) begin
                fin_c        = 1'b1;
                fin_status_c = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_FIND;
              end
            end
            default: begin
              fin_c = 1'b1;
            end
          endcase
        end
      end

      // Read the neighbor that moves into the current slot.
      S_SHIFT_RD: begin
        if (op_r == OP_INSERT) begin
          rd_addr_c = idx_r - AW'(1);
        end else begin
          rd_addr_c = idx_r + AW'(1);
        end
        state_nxt = S_SHIFT_WR;
      end

      // Write the moved entry and step toward the end of the shift.
      S_SHIFT_WR: begin
        wr_c = '{en: 1'b1, addr: idx_r, data: rd_data};
        if (op_r == OP_INSERT) begin
          idx_nxt = idx_r - AW'(1);
          if (idx_nxt == pos_r) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          idx_nxt = idx_r + AW'(1);
          if (CW'(idx_nxt) == count_r - CW'(1)) begin
            fin_c     = 1'b1;
            count_nxt = count_r - CW'(1);
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end
      end

      // Place the inserted entry into the opened slot.
      S_PUT: begin
        wr_c      = '{en: 1'b1, addr: pos_r, data: val_r};
        count_nxt = count_r + CW'(1);
        fin_c     = 1'b1;
        state_nxt = S_IDLE;
      end

      // Read data arrived from the accepting edge.
      S_GET: begin
        fin_c     = 1'b1;
        fin_rd_c  = rd_data;
        state_nxt = S_IDLE;
      end

      // Compare one entry per cycle while the next one is being read.
      S_FIND: begin
        rd_addr_c = idx_r + AW'(1);
        found_nxt = found_r | hit_c;
        fpos_nxt  = hit_c ? idx_r : fpos_r;
        idx_nxt   = idx_r + AW'(1);
        if (CW'(idx_r) == count_r - CW'(1)) begin
          fin_c        = 1'b1;
          fin_status_c = found_nxt ? ST_OK : ST_NOTFOUND;
          fin_fpos_c   = found_nxt ? fpos_nxt : '0;
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_read_value     = out_read_value_r;
  assign out_found_position = out_found_position_r;
  assign out_entry_count    = out_entry_count_r;
  assign out_is_full        = out_is_full_r;
  assign out_is_empty       = out_is_empty_r;

  // The count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds store depth");

  // Shifting only happens for insert and delete.
  a_shift_op: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |->
      (op_r == OP_INSERT || op_r == OP_DELETE))
    else $error("shift sequence running for a non-shifting operation");

  // A find on an empty list reports not found in the next cycle.
  a_find_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_c && in_op == OP_FIND && count_r == '0) |=>
      (out_valid && out_status == ST_NOTFOUND && !busy))
    else $error("find on empty list did not report not found");

  // A result strobe only ever follows a finishing step.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(fin_c))
    else $error("result strobe without a finishing step");

endmodule

FILE: tb/indexed_array_list_engine_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the indexed array list engine.
// Runs a stimulus table and random operation mixes against an in-bench list predictor.
// Depends on ials_pkg and indexed_array_list_engine_top.
module indexed_array_list_engine_top_tb;
  import ials_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 80;

  // Operation codes the block leaves unused.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // One result as the block reports it.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_value;
    logic [4:0]  found_pos;
    logic [5:0]  count;
    logic        full;
    logic        empty;
  } list_result_t;

  // One row of the stimulus table.
  typedef struct {
    logic [2:0]   op;
    logic [4:0]   pos;
    logic [31:0]  val;
    bit           pinned;
    list_result_t res;
  } table_row_t;

  // One phase of random operations under a fixed capacity.
  typedef struct {
    logic [5:0] cap;
    int         grow_pct;
    int         shrink_pct;
    int         idle_pct;
    int         items;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = OP_APPEND;
  logic [4:0]  in_position = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_read_value;
  logic [4:0]  out_found_position;
  logic [5:0]  out_entry_count;
  logic        out_is_full;
  logic        out_is_empty;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [5:0]  cfg_data = '0;

  // Typed-in expectation that travels with a table item.
  bit           pin_valid = 1'b0;
  list_result_t pin_res = '0;

  // Predictor state: list contents, length and capacity register.
  logic [31:0]  model_entries [DEPTH];
  int unsigned  model_len = 0;
  logic [5:0]   model_capacity = 6'd32;

  list_result_t awaited_results [$];
  table_row_t   stim_table [$];
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  event         item_taken;

  // Values that recur often so that lists hold duplicates.
  logic [31:0]  common_values [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000};

  indexed_array_list_engine_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_entry_count    (out_entry_count),
    .out_is_full        (out_is_full),
    .out_is_empty       (out_is_empty),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Applies one operation to the predicted list and returns the result it gives.
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [4:0] pos,
                                                 logic [31:0] val);
    list_result_t res;
    int unsigned  limit;
    bit           was_full;
    res = '0;
    res.status = ST_OK;
    limit = (model_capacity > DEPTH) ? DEPTH : model_capacity;
    was_full = (model_len >= limit);
    case (op)
      OP_APPEND: begin
        if (was_full) begin
          res.status = ST_FULL;
        end else begin
          model_entries[model_len] = val;
          model_len++;
        end
      end
      OP_INSERT: begin
        if (was_full) begin
          res.status = ST_FULL;
        end else if (pos > model_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = model_len; i > pos; i--) model_entries[i] = model_entries[i - 1];
          model_entries[pos] = val;
          model_len++;
        end
      end
      OP_EDIT: begin
        if (pos >= model_len) res.status = ST_BADIDX;
        else model_entries[pos] = val;
      end
      OP_DELETE: begin
        if (model_len == 0) begin
          res.status = ST_EMPTY;
        end else if (pos >= model_len) begin
          res.status = ST_BADIDX;
        end else begin
          for (int i = pos; i + 1 < model_len; i++) model_entries[i] = model_entries[i + 1];
          model_len--;
        end
      end
      OP_GET: begin
        if (pos >= model_len) res.status = ST_BADIDX;
        else res.read_value = model_entries[pos];
      end
      OP_FIND: begin
        // The last match wins, so the highest index is reported.
        res.status = ST_NOTFOUND;
        for (int i = 0; i < model_len; i++) begin
          if (model_entries[i] == val) begin
            res.status = ST_OK;
            res.found_pos = i[4:0];
          end
        end
      end
      default: begin
      end
    endcase
    res.count = model_len[5:0];
    res.full = (model_len >= limit);
    res.empty = (model_len == 0);
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // Result checking, predictor update on each accepted item, and the watchdog.
  always @(posedge clk) begin
    list_result_t want;
    bit           progress;
    progress = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        progress = 1'b1;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with none expected, expected none, actual status %0d",
                   $time, out_status);
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("read_value", want.read_value, out_read_value);
          check_field("found_position", want.found_pos, out_found_position);
          check_field("entry_count", want.count, out_entry_count);
          check_field("is_full", want.full, out_is_full);
          check_field("is_empty", want.empty, out_is_empty);
        end
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        model_capacity = cfg_data;
      end
      if (start && !busy) begin
        progress = 1'b1;
        want = apply_list_op(in_op, in_position, in_value);
        if (pin_valid) want = pin_res;
        awaited_results.push_back(want);
        -> item_taken;
      end
      stall_cycles = progress ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic [2:0] op, input logic [4:0] pos, input logic [31:0] val,
                           input bit pin, input list_result_t res, input int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    start       <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    pin_valid   <= pin;
    pin_res     <= res;
    @(item_taken);
  endtask

  // Picks a random operation, mostly with a position and value that make sense for the list.
  task automatic send_random(input int grow_pct, input int shrink_pct, input int idle_pct);
    int          r;
    int unsigned top;
    logic [2:0]  op;
    logic [4:0]  pos;
    logic [31:0] val;
    r = $urandom_range(0, 99);
    if (r < 3) op = ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
    else if (r < 3 + grow_pct) op = r[0] ? OP_APPEND : OP_INSERT;
    else if (r < 3 + grow_pct + shrink_pct) op = OP_DELETE;
    else begin
      case ($urandom_range(0, 2))
        0: op = OP_EDIT;
        1: op = OP_GET;
        default: op = OP_FIND;
      endcase
    end

    if ($urandom_range(0, 99) < 20 || (model_len == 0 && op != OP_INSERT)) begin
      pos = 5'($urandom_range(0, 31));
    end else if (op == OP_INSERT) begin
      top = (model_len > 31) ? 31 : model_len;
      pos = 5'($urandom_range(0, top));
    end else begin
      pos = 5'($urandom_range(0, model_len - 1));
    end

    if (op == OP_FIND && model_len != 0 && $urandom_range(0, 99) < 70)
      val = model_entries[$urandom_range(0, model_len - 1)];
    else if ($urandom_range(0, 3) == 0)
      val = common_values[$urandom_range(0, 3)];
    else
      val = $urandom();

    send_item(op, pos, val, 1'b0, '0, idle_pct);
  endtask

  task automatic write_capacity(input logic [5:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic table_row_t plain_row(logic [2:0] op, logic [4:0] pos, logic [31:0] val);
    table_row_t row;
    row.op = op;
    row.pos = pos;
    row.val = val;
    row.pinned = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic table_row_t pinned_row(logic [2:0] op, logic [4:0] pos, logic [31:0] val,
                                            logic [2:0] st, logic [5:0] cnt, bit full,
                                            bit empty);
    table_row_t row;
    row = plain_row(op, pos, val);
    row.pinned = 1'b1;
    row.res.status = st;
    row.res.count = cnt;
    row.res.full = full;
    row.res.empty = empty;
    return row;
  endfunction

  initial begin
    phase_t plan [8];

    // Directed items: errors on the empty list, spare codes, edge positions and values.
    stim_table.push_back(pinned_row(OP_GET, 5'd0, 32'h0, ST_BADIDX, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_DELETE, 5'd0, 32'h0, ST_EMPTY, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_FIND, 5'd0, 32'h0, ST_NOTFOUND, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_EDIT, 5'd0, 32'h1, ST_BADIDX, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_SPARE_LO, 5'd31, 32'hFFFF_FFFF, ST_OK, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_INSERT, 5'd1, 32'h5, ST_BADIDX, 6'd0, 1'b0, 1'b1));
    stim_table.push_back(pinned_row(OP_INSERT, 5'd0, 32'hFFFF_FFFF, ST_OK, 6'd1, 1'b0, 1'b0));
    stim_table.push_back(plain_row(OP_APPEND, 5'd31, 32'h0000_0000));
    stim_table.push_back(plain_row(OP_APPEND, 5'd0, 32'hA5A5_5A5A));
    stim_table.push_back(plain_row(OP_INSERT, 5'd1, 32'hFFFF_FFFF));
    stim_table.push_back(plain_row(OP_FIND, 5'd0, 32'hFFFF_FFFF));
    stim_table.push_back(plain_row(OP_GET, 5'd3, 32'h0));
    stim_table.push_back(pinned_row(OP_GET, 5'd31, 32'h0, ST_BADIDX, 6'd4, 1'b0, 1'b0));
    stim_table.push_back(plain_row(OP_EDIT, 5'd2, 32'h8000_0001));
    stim_table.push_back(plain_row(OP_DELETE, 5'd0, 32'h0));
    stim_table.push_back(pinned_row(OP_DELETE, 5'd31, 32'h0, ST_BADIDX, 6'd3, 1'b0, 1'b0));
    stim_table.push_back(pinned_row(OP_FIND, 5'd0, 32'h1234_5678, ST_NOTFOUND, 6'd3, 1'b0,
                                    1'b0));
    // An insert at the current length behaves as an append.
    stim_table.push_back(plain_row(OP_INSERT, 5'd3, 32'h7FFF_FFFF));
    stim_table.push_back(pinned_row(OP_INSERT, 5'd5, 32'h0, ST_BADIDX, 6'd4, 1'b0, 1'b0));
    stim_table.push_back(plain_row(OP_GET, 5'd0, 32'h0));
    stim_table.push_back(pinned_row(OP_SPARE_HI, 5'd0, 32'h0, ST_OK, 6'd4, 1'b0, 1'b0));
    stim_table.push_back(pinned_row(OP_EDIT, 5'd31, 32'h0, ST_BADIDX, 6'd4, 1'b0, 1'b0));

    // Random phases: capacity above the store, below the count, zero, one and in between.
    plan[0] = '{6'd63, 60, 10, 15, 150};
    plan[1] = '{6'd5, 10, 50, 10, 130};
    plan[2] = '{6'd0, 30, 20, 20, 100};
    plan[3] = '{6'd1, 50, 10, 0, 110};
    plan[4] = '{6'd32, 55, 10, 15, 140};
    plan[5] = '{6'd32, 10, 55, 15, 130};
    plan[6] = '{6'd0, 35, 25, 15, 130};
    plan[6].cap = 6'($urandom_range(0, 63));
    plan[7] = '{6'd17, 40, 25, 0, 130};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i])
      send_item(stim_table[i].op, stim_table[i].pos, stim_table[i].val, stim_table[i].pinned,
                stim_table[i].res, 15);

    // Capacity changes only once every result of the previous phase is in.
    foreach (plan[p]) begin
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
      repeat (2) @(posedge clk);
      write_capacity(plan[p].cap);
      repeat (plan[p].items) send_random(plan[p].grow_pct, plan[p].shrink_pct, plan[p].idle_pct);
    end

    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
